FILE: hdl/sfp_pkg.sv
// shared constants and types for the sbus frame parser
package sfp_pkg;

    localparam int FRAME_BYTES   = 25;
    localparam int CHANNEL_BITS  = 11;
    localparam int NUM_CHANNELS  = 16;
    localparam int INDEX_BITS    = $clog2(NUM_CHANNELS);
    localparam int COUNT_BITS    = $clog2(FRAME_BYTES + 1);
    // bytes 1 to 23 of a frame: payload plus flags byte
    localparam int STORE_BYTES   = FRAME_BYTES - 2;
    localparam int STORE_BITS    = STORE_BYTES * 8;
    localparam int PAYLOAD_BITS  = NUM_CHANNELS * CHANNEL_BITS;
    localparam int FLAGS_LSB     = (STORE_BYTES - 1) * 8;
    localparam int LOST_BIT      = FLAGS_LSB + 2;
    localparam int FAILSAFE_BIT  = FLAGS_LSB + 3;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [7:0] START_MARK = 8'h0F;
    localparam logic [7:0] END_MARK   = 8'h00;

    // one complete good frame, handed from front to back
    typedef struct packed {
        logic [PAYLOAD_BITS-1:0] payload;
        logic                    frame_lost;
        logic                    failsafe;
    } frame_t;

endpackage

FILE: hdl/sfp_front.sv
// front end: start detection, byte counting and frame collection
module sfp_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            byte_valid,
    input  logic [7:0]      byte_data,
    output logic            push,
    output sfp_pkg::frame_t push_frame
);

    logic                                in_frame_reg, in_frame_next;
    logic [sfp_pkg::COUNT_BITS-1:0]      count_reg, count_next;
    logic [sfp_pkg::STORE_BITS-1:0]      store_reg, store_next;
    logic                                frame_done;

    // last byte of the frame arrives while bytes 1 to 23 are stored
    assign frame_done = in_frame_reg
                      && (count_reg == sfp_pkg::COUNT_BITS'(sfp_pkg::FRAME_BYTES - 1));

    always_comb begin
        in_frame_next = in_frame_reg;
        count_next    = count_reg;
        store_next    = store_reg;
        if (byte_valid) begin
            if (!in_frame_reg) begin
                if (byte_data == sfp_pkg::START_MARK) begin
                    in_frame_next = 1'b1;
                    count_next    = sfp_pkg::COUNT_BITS'(1);
                end
            end else if (frame_done) begin
                in_frame_next = 1'b0;
                count_next    = '0;
            end else begin
                // newest byte enters at the top, frame byte 1 ends at the bottom
                store_next = {byte_data, store_reg[sfp_pkg::STORE_BITS-1:8]};
                count_next = count_reg + sfp_pkg::COUNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg <= 1'b0;
            count_reg    <= '0;
        end else begin
            in_frame_reg <= in_frame_next;
            count_reg    <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        store_reg <= store_next;
    end

    assign push = byte_valid && frame_done && (byte_data == sfp_pkg::END_MARK);
    assign push_frame.payload    = store_reg[sfp_pkg::PAYLOAD_BITS-1:0];
    assign push_frame.frame_lost = store_reg[sfp_pkg::LOST_BIT];
    assign push_frame.failsafe   = store_reg[sfp_pkg::FAILSAFE_BIT];

endmodule

FILE: hdl/sfp_queue.sv
// small frame queue between front end and channel emitter
module sfp_queue #(
    parameter int DEPTH = sfp_pkg::QUEUE_DEPTH
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  sfp_pkg::frame_t push_frame,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output sfp_pkg::frame_t head_frame
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    sfp_pkg::frame_t   entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;

    assign full       = (fill_reg == CNT_W'(DEPTH));
    assign not_empty  = (fill_reg != '0);
    assign head_frame = entry_reg[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        r = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
        return r;
    endfunction

    always_comb begin
        wr_ptr_next = push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? bump(rd_ptr_reg) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop) begin
            fill_next = fill_reg + CNT_W'(1);
        end else if (pop && !push) begin
            fill_next = fill_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_frame;
        end
    end

endmodule

FILE: hdl/sfp_back.sv
// channel emitter: walks one frame out as 16 channel words
module sfp_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           frame_avail,
    input  sfp_pkg::frame_t                frame_in,
    output logic                           pop,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [sfp_pkg::INDEX_BITS-1:0] out_index,
    output logic [sfp_pkg::CHANNEL_BITS-1:0] out_value,
    output logic                           out_lost,
    output logic                           out_failsafe,
    output logic                           out_last
);

    logic                              busy_reg, busy_next;
    logic [sfp_pkg::INDEX_BITS-1:0]    chan_reg, chan_next;
    logic [sfp_pkg::PAYLOAD_BITS-1:0]  data_reg, data_next;
    logic                              lost_reg, lost_next;
    logic                              fs_reg, fs_next;
    logic                              is_last;
    logic                              take;

    assign is_last = (chan_reg == sfp_pkg::INDEX_BITS'(sfp_pkg::NUM_CHANNELS - 1));
    assign take    = busy_reg && out_ready;
    // load the next frame when idle or as the last channel leaves
    assign pop     = frame_avail && (!busy_reg || (take && is_last));

    always_comb begin
        busy_next = busy_reg;
        chan_next = chan_reg;
        data_next = data_reg;
        lost_next = lost_reg;
        fs_next   = fs_reg;
        if (pop) begin
            busy_next = 1'b1;
            chan_next = '0;
            data_next = frame_in.payload;
            lost_next = frame_in.frame_lost;
            fs_next   = frame_in.failsafe;
        end else if (take) begin
            if (is_last) begin
                busy_next = 1'b0;
            end
            chan_next = chan_reg + sfp_pkg::INDEX_BITS'(1);
            data_next = data_reg >> sfp_pkg::CHANNEL_BITS;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            chan_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            chan_reg <= chan_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        lost_reg <= lost_next;
        fs_reg   <= fs_next;
    end

    assign out_valid    = busy_reg;
    assign out_index    = chan_reg;
    assign out_value    = data_reg[sfp_pkg::CHANNEL_BITS-1:0];
    assign out_lost     = lost_reg;
    assign out_failsafe = fs_reg;
    assign out_last     = is_last;

endmodule

FILE: hdl/sbus_frame_parser_core.sv
// top level of the sbus frame parser: front end, frame queue, channel emitter
//
//  channel  direction  ports                                  word
//  s_       in         s_valid s_ready s_rx_byte              one received byte
//  m_       out        m_valid m_ready m_channel_index ...    one decoded channel
//
// bytes are taken one per cycle whenever the frame queue has room
// a good frame yields 16 words, one per cycle while m_ready is high; the first
//   is valid at the earliest once the frame is written into the queue and then loaded into the emitter
// the emitter holds one frame and the queue QUEUE_DEPTH more, so input stalls
//   only when that many frames wait behind a stalled output
// reset is synchronous, active low: parser back to waiting for the start byte,
//   queue empty, no word pending
module sbus_frame_parser_core #(
    parameter int QUEUE_DEPTH = sfp_pkg::QUEUE_DEPTH
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // byte input
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [7:0]                       s_rx_byte,
    // channel output
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [sfp_pkg::INDEX_BITS-1:0]   m_channel_index,
    output logic [sfp_pkg::CHANNEL_BITS-1:0] m_channel_value,
    output logic                             m_frame_lost,
    output logic                             m_failsafe,
    output logic                             m_last
);

    logic            q_full;
    logic            q_not_empty;
    logic            q_push;
    logic            q_pop;
    logic            byte_take;
    sfp_pkg::frame_t push_frame;
    sfp_pkg::frame_t head_frame;

    // a full queue holds off bytes, so a completing frame always has a slot
    assign s_ready   = !q_full;
    assign byte_take = s_valid && s_ready;

    // start detection, counting and byte collection
    sfp_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_valid (byte_take),
        .byte_data  (s_rx_byte),
        .push       (q_push),
        .push_frame (push_frame)
    );

    // decouples byte intake from channel output
    sfp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_frame (push_frame),
        .full       (q_full),
        .pop        (q_pop),
        .not_empty  (q_not_empty),
        .head_frame (head_frame)
    );

    // unpacks 11-bit channels lsb first, one per accepted word
    sfp_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .frame_avail  (q_not_empty),
        .frame_in     (head_frame),
        .pop          (q_pop),
        .out_valid    (m_valid),
        .out_ready    (m_ready),
        .out_index    (m_channel_index),
        .out_value    (m_channel_value),
        .out_lost     (m_frame_lost),
        .out_failsafe (m_failsafe),
        .out_last     (m_last)
    );

endmodule
